@@ sv/randomized_set_table_defines.svh @@
// Assertion macros for the randomized set table.
// Used by the top level only; depends on clk and rst in the including scope.
`ifndef RANDOMIZED_SET_TABLE_DEFINES_SVH
`define RANDOMIZED_SET_TABLE_DEFINES_SVH
`ifndef SYNTH
`define RSET_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RSET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RSET_ASSERT_NOW(lbl, ante, cons, msg)
`define RSET_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/rset_pkg.sv @@
// Types and constants shared by the randomized set table modules.
// No dependencies.
package rset_pkg;

  localparam int VALUE_W = 32;
  localparam int DRAW_W  = 16;
  localparam int STEP_W  = 4;
  localparam int COUNT_W = 7;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_PICK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic [1:0]        req_type;
    value_t            value;
    logic [DRAW_W-1:0] random_draw;
  } request_t;

  typedef struct packed {
    logic [1:0]         status;
    value_t             picked_value;
    logic [COUNT_W-1:0] member_count;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_MOVE_RD,
    S_MOVE_WR,
    S_MOD_GO,
    S_MOD_RUN,
    S_PICK_RD,
    S_PICK_TAKE,
    S_DONE
  } state_e;

endpackage

@@ sv/rset_mem.sv @@
// Value store: one write port, one read port with registered read data.
// Depends on rset_pkg.
module rset_mem import rset_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  value_t        wdata,
  input  logic [AW-1:0] raddr,
  output value_t        rdata
);

  value_t store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= store[raddr];
  end

endmodule

@@ sv/rset_mod.sv @@
// Bit-serial remainder unit: draw modulo member count, one dividend bit per cycle.
// Depends on rset_pkg.
module rset_mod import rset_pkg::*; #(
  parameter int CW = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DRAW_W-1:0] dividend,
  input  logic [CW-1:0]     divisor,
  output logic              done,
  output logic [CW-1:0]     rem
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DRAW_W - 1);

  logic              running;
  logic [STEP_W-1:0] step;
  logic [DRAW_W-1:0] dvd;
  logic [CW-1:0]     dsr;
  logic [CW:0]       trial;
  logic [CW:0]       diff;
  logic [CW-1:0]     rem_next;

  always_comb begin
    trial    = {rem, dvd[DRAW_W-1]};
    diff     = trial - {1'b0, dsr};
    rem_next = (trial >= {1'b0, dsr}) ? diff[CW-1:0] : trial[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && step == LAST_STEP) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step <= '0;
      dvd  <= dividend;
      dsr  <= divisor;
      rem  <= '0;
    end else if (running) begin
      step <= step + STEP_W'(1);
      dvd  <= {dvd[DRAW_W-2:0], 1'b0};
      rem  <= rem_next;
    end
  end

endmodule

@@ sv/randomized_set_table.sv @@
// Randomized set table: insert and remove scan the set one entry per cycle through the
// store read port; remove then moves the last entry into the freed slot, and pick runs
// the 16-step remainder unit and reads the chosen entry. One item at a time; start is
// taken again the cycle after done, and done is high for one cycle only, since the
// receiver cannot stall.
// Synchronous reset empties the set; store contents stay undefined until written.
`include "randomized_set_table_defines.svh"
module randomized_set_table import rset_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_e        state, state_next;
  request_t      req;
  logic [CW-1:0] count;
  logic [CW-1:0] scan_idx;
  logic          pend;
  logic [AW-1:0] pend_idx;
  logic [AW-1:0] hit_pos;
  logic [AW-1:0] pick_idx;
  logic [1:0]    status;
  value_t        picked;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  value_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  value_t        mem_rdata;

  logic          mod_start;
  logic          mod_done;
  logic [CW-1:0] mod_rem;

  logic          scan_more;
  logic          hit;
  logic          miss;
  logic          full;
  logic [CW-1:0] last_idx;

  rset_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rset_mod #(.CW(CW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (req.random_draw),
    .divisor  (count),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    scan_more = scan_idx < count;
    hit       = pend && (mem_rdata == req.value);
    miss      = !pend && !scan_more;
    full      = count >= CAP_C;
    last_idx  = count - CW'(1);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (request.req_type)
            REQ_INSERT, REQ_REMOVE: state_next = S_SEARCH;
            REQ_PICK:               state_next = (count == '0) ? S_DONE : S_MOD_GO;
            default:                state_next = S_DONE;
          endcase
        end
      end
      S_SEARCH: begin
        if (hit) begin
          state_next = (req.req_type == REQ_REMOVE) ? S_MOVE_RD : S_DONE;
        end else if (miss) begin
          state_next = S_DONE;
        end
      end
      S_MOVE_RD:   state_next = S_MOVE_WR;
      S_MOVE_WR:   state_next = S_DONE;
      S_MOD_GO:    state_next = S_MOD_RUN;
      S_MOD_RUN: begin
        if (mod_done) begin
          state_next = S_PICK_RD;
        end
      end
      S_PICK_RD:   state_next = S_PICK_TAKE;
      S_PICK_TAKE: state_next = S_DONE;
      S_DONE:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy      = state != S_IDLE;
    done      = state == S_DONE;
    mod_start = state == S_MOD_GO;
    mem_we    = 1'b0;
    mem_waddr = count[AW-1:0];
    mem_wdata = req.value;
    mem_raddr = scan_idx[AW-1:0];
    unique case (state)
      S_SEARCH: begin
        mem_we = !hit && miss && (req.req_type == REQ_INSERT) && !full;
      end
      S_MOVE_RD: begin
        mem_raddr = last_idx[AW-1:0];
      end
      S_MOVE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = hit_pos;
        mem_wdata = mem_rdata;
      end
      S_PICK_RD: begin
        mem_raddr = pick_idx;
      end
      default: begin
      end
    endcase
    result.status       = status;
    result.picked_value = picked;
    result.member_count = COUNT_W'(count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_SEARCH && !hit && miss && req.req_type == REQ_INSERT && !full) begin
        count <= count + CW'(1);
      end else if (state == S_MOVE_WR) begin
        count <= last_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          req      <= request;
          scan_idx <= '0;
          pend     <= 1'b0;
          picked   <= '0;
          status   <= (request.req_type == REQ_PICK && count == '0) ? ST_EMPTY : ST_OK;
        end
      end
      S_SEARCH: begin
        if (scan_more) begin
          scan_idx <= scan_idx + CW'(1);
          pend     <= 1'b1;
          pend_idx <= scan_idx[AW-1:0];
        end else begin
          pend <= 1'b0;
        end
        if (hit) begin
          hit_pos <= pend_idx;
          if (req.req_type == REQ_INSERT) begin
            status <= ST_MISS;
          end
        end else if (miss) begin
          if (req.req_type == REQ_REMOVE) begin
            status <= ST_MISS;
          end else if (full) begin
            status <= ST_FULL;
          end
        end
      end
      S_MOD_RUN: begin
        if (mod_done) begin
          pick_idx <= mod_rem[AW-1:0];
        end
      end
      S_PICK_TAKE: begin
        picked <= mem_rdata;
      end
      default: begin
      end
    endcase
  end

  `RSET_ASSERT_NOW(a_count_bound, 1'b1, count <= CAP_C, "member count above capacity")
  `RSET_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `RSET_ASSERT_NEXT(a_done_idle, done, !busy, "block still busy after done")
  `RSET_ASSERT_NOW(a_write_busy, mem_we, busy, "store written while idle")

endmodule

@@ test/randomized_set_table_tb.sv @@
// Self-checking testbench for randomized_set_table: directed and random insert, remove
// and pick requests, each result checked against an in-bench model of the set.
// Depends on rset_pkg and the randomized_set_table RTL.
module randomized_set_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rset_pkg::*;

  localparam int CAPACITY         = 64;
  localparam int RANDOM_REQUESTS  = 1200;
  localparam int TAIL_CYCLES      = 80;
  localparam int CYCLE_LIMIT      = 1000000;
  localparam int SHOWN_MISMATCHES = 10;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    request_t req;
    bit       wait_idle;
  } queued_item_t;

  logic     clk;
  logic     rst     = 1'b1;
  logic     start   = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;

  randomized_set_table #(.CAPACITY(CAPACITY)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  value_t       set_vals [CAPACITY];
  int           set_count = 0;
  result_t      expected_results [$];
  queued_item_t pending [$];
  value_t       plan_set [$];
  int unsigned  in_flight = 0;
  int unsigned  burst_left = 1;
  int unsigned  gap_left = 0;
  int unsigned  planned_requests = 0;
  int unsigned  checked = 0;
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  int unsigned  status_seen [4] = '{0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic result_t apply_request(input request_t rq);
    result_t r;
    int      pos;
    r.status       = ST_OK;
    r.picked_value = '0;
    pos            = -1;
    for (int i = 0; i < set_count; i++)
      if (pos < 0 && set_vals[i] == rq.value) pos = i;
    case (rq.req_type)
      REQ_INSERT: begin
        if (pos >= 0) r.status = ST_MISS;
        else if (set_count >= CAPACITY) r.status = ST_FULL;
        else begin
          set_vals[set_count] = rq.value;
          set_count++;
        end
      end
      REQ_REMOVE: begin
        if (pos < 0) r.status = ST_MISS;
        else begin
          set_vals[pos] = set_vals[set_count-1];
          set_count--;
        end
      end
      REQ_PICK: begin
        if (set_count == 0) r.status = ST_EMPTY;
        else r.picked_value = set_vals[int'(rq.random_draw) % set_count];
      end
      default: ;
    endcase
    r.member_count = COUNT_W'(set_count);
    return r;
  endfunction

  function automatic int plan_index(input value_t v);
    foreach (plan_set[i])
      if (plan_set[i] == v) return i;
    return -1;
  endfunction

  function automatic value_t pool_value();
    case ($urandom_range(0, 5))
      0:       return value_t'(32'sh80000000) + value_t'($urandom_range(0, 3));
      1:       return value_t'(32'sh7FFFFFFF) - value_t'($urandom_range(0, 3));
      default: return value_t'($urandom_range(0, 15)) - value_t'(8);
    endcase
  endfunction

  function automatic value_t fresh_value();
    value_t v;
    do begin
      v = ($urandom_range(0, 3) == 0) ? pool_value() : value_t'($urandom);
    end while (plan_index(v) >= 0);
    return v;
  endfunction

  function automatic value_t some_member();
    return plan_set[$urandom_range(0, plan_set.size() - 1)];
  endfunction

  function automatic logic [DRAW_W-1:0] any_draw();
    return DRAW_W'($urandom);
  endfunction

  task automatic queue_item(input logic [1:0] kind, input value_t val,
                            input logic [DRAW_W-1:0] draw, input bit wait_idle);
    queued_item_t it;
    int           idx;
    idx              = plan_index(val);
    it.req.req_type  = kind;
    it.req.value     = val;
    it.req.random_draw = draw;
    it.wait_idle     = wait_idle;
    pending.insert(pending.size(), it);
    if (kind == REQ_INSERT && idx < 0 && plan_set.size() < CAPACITY)
      plan_set.insert(plan_set.size(), val);
    else if (kind == REQ_REMOVE && idx >= 0) plan_set.delete(idx);
    if (kind != REQ_UNUSED) planned_requests++;
  endtask

  task automatic flag_mismatch(input string what, input result_t exp);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES)
      $display("%0t: %s: expected status %0d value %0d count %0d, got status %0d value %0d count %0d",
               $realtime, what, exp.status, exp.picked_value, exp.member_count,
               result.status, result.picked_value, result.member_count);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start      <= 1'b0;
      request    <= '0;
      burst_left <= 1;
      gap_left   <= 0;
    end else if (!start || !busy) begin
      if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending.size() == 0) begin
        start <= 1'b0;
      end else if (pending[0].wait_idle && (start || busy || in_flight != 0)) begin
        start <= 1'b0;
      end else begin
        request <= pending[0].req;
        start   <= 1'b1;
        void'(pending.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t exp;
    if (!rst) begin
      if (start && !busy)
        expected_results.insert(expected_results.size(), apply_request(request));
      if (done) begin
        checked++;
        if (expected_results.size() == 0) begin
          flag_mismatch("result with nothing expected", '0);
        end else begin
          exp = expected_results.pop_front();
          status_seen[exp.status]++;
          if (result.status !== exp.status || result.picked_value !== exp.picked_value ||
              result.member_count !== exp.member_count)
            flag_mismatch("result mismatch", exp);
        end
      end
      in_flight <= expected_results.size();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    int segment;
    int len;
    int roll;
    bit hold;
    bit first_segment;

    queue_item(REQ_PICK,   '0, '0, 1'b0);
    queue_item(REQ_PICK,   '0, 16'hFFFF, 1'b0);
    queue_item(REQ_REMOVE, value_t'(5), '0, 1'b0);
    queue_item(REQ_UNUSED, value_t'(32'shFFFFFFFF), 16'hFFFF, 1'b0);
    queue_item(REQ_INSERT, value_t'(32'sh80000000), '0, 1'b0);
    queue_item(REQ_INSERT, value_t'(32'sh7FFFFFFF), '0, 1'b0);
    queue_item(REQ_INSERT, value_t'(0), '0, 1'b0);
    queue_item(REQ_INSERT, value_t'(-1), '0, 1'b0);
    queue_item(REQ_INSERT, value_t'(32'sh80000000), '0, 1'b0);
    queue_item(REQ_PICK,   '0, 16'h0000, 1'b0);
    queue_item(REQ_PICK,   value_t'(-1), 16'hFFFF, 1'b0);
    queue_item(REQ_PICK,   '0, 16'h0002, 1'b0);
    queue_item(REQ_REMOVE, value_t'(32'sh7FFFFFFF), '0, 1'b0);
    queue_item(REQ_PICK,   '0, 16'h0001, 1'b0);
    queue_item(REQ_REMOVE, value_t'(-1), '0, 1'b0);
    queue_item(REQ_REMOVE, value_t'(12345), '0, 1'b0);
    queue_item(REQ_UNUSED, '0, '0, 1'b0);
    queue_item(REQ_REMOVE, value_t'(32'sh80000000), '0, 1'b0);
    queue_item(REQ_REMOVE, value_t'(0), '0, 1'b0);
    queue_item(REQ_PICK,   '0, 16'h5555, 1'b0);
    queue_item(REQ_INSERT, value_t'(32'sh5555AAAA), '0, 1'b0);
    queue_item(REQ_INSERT, value_t'(32'shAAAA5555), '0, 1'b0);
    queue_item(REQ_PICK,   '0, 16'h5555, 1'b0);
    queue_item(REQ_PICK,   '0, 16'hAAAA, 1'b0);

    first_segment = 1'b1;
    while (planned_requests < RANDOM_REQUESTS + 20) begin
      segment = $urandom_range(0, 9);
      hold    = first_segment || segment inside {6, 7} || $urandom_range(0, 5) == 0;
      first_segment = 1'b0;
      if (segment <= 5) begin
        len = $urandom_range(10, 40);
        repeat (len) begin
          roll = $urandom_range(0, 99);
          if (roll < 40) begin
            roll = $urandom_range(0, 9);
            if (roll < 5) queue_item(REQ_INSERT, pool_value(), any_draw(), hold);
            else if (roll < 7 && plan_set.size() > 0)
              queue_item(REQ_INSERT, some_member(), any_draw(), hold);
            else queue_item(REQ_INSERT, value_t'($urandom), any_draw(), hold);
          end else if (roll < 70) begin
            if ($urandom_range(0, 9) < 6 && plan_set.size() > 0)
              queue_item(REQ_REMOVE, some_member(), any_draw(), hold);
            else if ($urandom_range(0, 1) == 0)
              queue_item(REQ_REMOVE, pool_value(), any_draw(), hold);
            else queue_item(REQ_REMOVE, value_t'($urandom), any_draw(), hold);
          end else if (roll < 97) begin
            queue_item(REQ_PICK, value_t'($urandom), any_draw(), hold);
          end else begin
            queue_item(REQ_UNUSED, value_t'($urandom), any_draw(), hold);
          end
          hold = 1'b0;
        end
      end else if (segment <= 7) begin
        while (plan_set.size() < CAPACITY) begin
          queue_item(REQ_INSERT, fresh_value(), any_draw(), hold);
          hold = 1'b0;
        end
        repeat ($urandom_range(1, 3)) queue_item(REQ_INSERT, fresh_value(), any_draw(), 1'b0);
        repeat ($urandom_range(1, 2)) queue_item(REQ_INSERT, some_member(), any_draw(), 1'b0);
        repeat ($urandom_range(2, 6))
          queue_item(REQ_PICK, value_t'($urandom), any_draw(), 1'b0);
      end else if (segment == 8) begin
        while (plan_set.size() > 0) begin
          if ($urandom_range(0, 4) == 0)
            queue_item(REQ_PICK, value_t'($urandom), any_draw(), hold);
          else queue_item(REQ_REMOVE, some_member(), any_draw(), hold);
          hold = 1'b0;
        end
        queue_item(REQ_PICK, value_t'($urandom), any_draw(), 1'b0);
        queue_item(REQ_REMOVE, pool_value(), any_draw(), 1'b0);
      end else begin
        len = $urandom_range(3, 10);
        repeat (len) begin
          queue_item(2'($urandom_range(0, 3)), value_t'($urandom), any_draw(), hold);
          hold = 1'b0;
        end
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending.size() != 0 || start || busy || in_flight != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_results.size() != 0)
      $display("%0d expected results never arrived", expected_results.size());
    $display("Checked %0d results for %0d requests in %0d cycles", checked, planned_requests,
             cycles);
    $display("Outcomes: %0d done, %0d present or absent, %0d full, %0d empty, %0d mismatches",
             status_seen[ST_OK], status_seen[ST_MISS], status_seen[ST_FULL],
             status_seen[ST_EMPTY], mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ randomized_set_table.f @@
+incdir+sv
sv/rset_pkg.sv
sv/rset_mem.sv
sv/rset_mod.sv
sv/randomized_set_table.sv
test/randomized_set_table_tb.sv
